// File: sv/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/shs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash, round functions and control structs.
// ----------------------------------------------------------------------------
package shs_pkg;

	// func field codes
	localparam logic FN_ABSORB = 1'b0;
	localparam logic FN_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       push;
		logic [5:0] pos;
		logic [7:0] data;
		logic       step;
		logic [5:0] kidx;
	} sched_ctl_t;

	typedef struct packed {
		logic       load;
		logic       round;
		logic       add;
		logic       emit;
		logic [2:0] oidx;
	} rnd_ctl_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// File: sv/shs_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher channels
// Valid/ready interfaces for message bytes and digest words.
// ----------------------------------------------------------------------------
interface shs_msg_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, func, data_byte, input ready);
	modport sink   (input valid, func, data_byte, output ready);
endinterface

interface shs_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/shs_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// 16-word window: byte fill from the stream, then one W[t]+K[t] per step.
// ----------------------------------------------------------------------------
module shs_sched (
	input  logic                clk,
	input  shs_pkg::sched_ctl_t ctl,
	output logic [31:0]         kw
);

	logic [31:0] win_q [16];
	logic [31:0] kw_q;
	logic [31:0] w_cur;

	// first 16 steps pass the block words through; window rotates back intact
	always_comb begin
		if (ctl.kidx[5:4] == 2'b00) begin
			w_cur = win_q[0];
		end else begin
			w_cur = win_q[0] + shs_pkg::small_sigma0(win_q[1]) + win_q[9]
				+ shs_pkg::small_sigma1(win_q[14]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_cur;
			kw_q      <= shs_pkg::ROUND_K[ctl.kidx] + w_cur;
		end else if (ctl.push) begin
			// big-endian: byte lane 0 lands in bits 31:24
			win_q[ctl.pos[5:2]][{~ctl.pos[1:0], 3'b000} +: 8] <= ctl.data;
		end
	end

	assign kw = kw_q;

endmodule

// File: sv/shs_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Hash words, working variables a..h and the shared one-round datapath.
// ----------------------------------------------------------------------------
module shs_round (
	input  logic              clk,
	input  logic              arst_n,
	input  shs_pkg::rnd_ctl_t ctl,
	input  logic [31:0]       kw,
	output logic [31:0]       digest_word
);

	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		t1 = work_q[7] + shs_pkg::big_sigma1(work_q[4])
			+ shs_pkg::choose(work_q[4], work_q[5], work_q[6]) + kw;
		t2 = shs_pkg::big_sigma0(work_q[0])
			+ shs_pkg::majority(work_q[0], work_q[1], work_q[2]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (ctl.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	// emit shifts the digest out of word 0 and refills with the initial hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shs_pkg::INIT_H[i];
			end
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end else if (ctl.emit) begin
			for (int i = 0; i < 7; i++) begin
				hash_q[i] <= hash_q[i + 1];
			end
			hash_q[7] <= shs_pkg::INIT_H[ctl.oidx];
		end
	end

	assign digest_word = hash_q[0];

endmodule

// File: sv/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with a shared one-round-per-cycle compression unit.
// ----------------------------------------------------------------------------
// Usage:
//  msg    : one beat per byte. func=0 absorbs data_byte, func=1 finishes the
//           message (data_byte ignored). ready is high only while idle.
//  digest : after a finish, eight beats of digest_word, word_index 0..7
//           (0 most significant), last_word on index 7.
// Timing:
//  - the 64th byte of a block starts a compression (a load, 64 rounds and
//    a hash add) that completes before ready returns.
//  - a finish with f bytes in the block pushes pad/length bytes at one per
//    cycle, pausing while a full block compresses: for f <= 55 the first
//    digest beat follows one compression; for f >= 56 it follows two.
//  - rate is set by the round unit: one round per cycle, 64 per block.
// Stall: digest words are held from registers until taken; the hash words
//  shift out one per beat and reload with the initial hash, so the next
//  message starts clean once the last word is taken.
// Reset: arst_n clears the counters and sequencer and loads the initial hash;
//  the message window and working variables carry no reset.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic      clk,
	input  logic      arst_n,
	shs_msg_if.sink   msg,
	shs_dig_if.source digest
);

	shs_pkg::state_t     state_q;
	shs_pkg::state_t     state_nx;
	shs_pkg::sched_ctl_t sched_ctl;
	shs_pkg::rnd_ctl_t   rnd_ctl;

	logic [5:0]  fill_q;       // bytes in the current block
	logic [31:0] bytes_q;      // message length in bytes, wraps at 2^32
	logic [5:0]  rnd_q;        // round counter
	logic        fin_q;        // finish in progress
	logic        first_q;      // next pad byte is the 0x80 marker
	logic        len_q;        // pushing the 64-bit bit length
	logic [2:0]  oidx_q;       // digest word on the output

	logic [31:0] kw;
	logic        msg_acc;
	logic        absorb;
	logic        finish;
	logic        push;
	logic        wrap;
	logic [5:0]  fill_nx;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic [7:0]  pad_data;
	logic        dig_acc;
	logic        dig_done;

	assign msg_acc  = msg.valid && msg.ready;
	assign absorb   = msg_acc && (msg.func == shs_pkg::FN_ABSORB);
	assign finish   = msg_acc && (msg.func == shs_pkg::FN_FINISH);
	assign dig_acc  = digest.valid && digest.ready;
	assign dig_done = dig_acc && (oidx_q == shs_pkg::LAST_WORD);

	// padding source: marker, zero fill, then big-endian bit length
	assign bit_len  = {29'd0, bytes_q, 3'b000};
	assign len_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (first_q) begin
			pad_data = shs_pkg::PAD_BYTE;
		end else if (len_q) begin
			pad_data = len_byte;
		end else begin
			pad_data = 8'h00;
		end
	end

	assign push    = absorb || (state_q == shs_pkg::ST_PAD);
	assign fill_nx = fill_q + 6'd1;
	assign wrap    = push && (&fill_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			shs_pkg::ST_IDLE: begin
				if (finish) begin
					state_nx = shs_pkg::ST_PAD;
				end else if (wrap) begin
					state_nx = shs_pkg::ST_LOAD;
				end
			end
			shs_pkg::ST_PAD: begin
				if (wrap) begin
					state_nx = shs_pkg::ST_LOAD;
				end
			end
			shs_pkg::ST_LOAD: begin
				state_nx = shs_pkg::ST_ROUND;
			end
			shs_pkg::ST_ROUND: begin
				if (rnd_q == shs_pkg::LAST_ROUND) begin
					state_nx = shs_pkg::ST_ADD;
				end
			end
			shs_pkg::ST_ADD: begin
				priority if (fin_q && len_q) begin
					state_nx = shs_pkg::ST_OUT;
				end else if (fin_q) begin
					state_nx = shs_pkg::ST_PAD;
				end else begin
					state_nx = shs_pkg::ST_IDLE;
				end
			end
			shs_pkg::ST_OUT: begin
				if (dig_done) begin
					state_nx = shs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = shs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and unit control
	always_comb begin
		msg.ready    = (state_q == shs_pkg::ST_IDLE);
		digest.valid = (state_q == shs_pkg::ST_OUT);

		sched_ctl.push = push;
		sched_ctl.pos  = fill_q;
		sched_ctl.data = (state_q == shs_pkg::ST_IDLE) ? msg.data_byte : pad_data;
		// schedule runs one step ahead of the rounds
		sched_ctl.step = (state_q == shs_pkg::ST_LOAD)
			|| ((state_q == shs_pkg::ST_ROUND) && (rnd_q != shs_pkg::LAST_ROUND));
		sched_ctl.kidx = (state_q == shs_pkg::ST_LOAD) ? 6'd0 : rnd_q + 6'd1;

		rnd_ctl.load  = (state_q == shs_pkg::ST_LOAD);
		rnd_ctl.round = (state_q == shs_pkg::ST_ROUND);
		rnd_ctl.add   = (state_q == shs_pkg::ST_ADD);
		rnd_ctl.emit  = dig_acc;
		rnd_ctl.oidx  = oidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::ST_IDLE;
			fill_q  <= '0;
			bytes_q <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (push) begin
				fill_q <= fill_nx;
			end
			if (absorb) begin
				bytes_q <= bytes_q + 32'd1;
			end else if (dig_done) begin
				bytes_q <= '0;
			end
			if (state_q == shs_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (finish) begin
				fin_q   <= 1'b1;
				first_q <= 1'b1;
			end else if (dig_done) begin
				fin_q <= 1'b0;
				len_q <= 1'b0;
			end else if (state_q == shs_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (!len_q && (fill_nx == shs_pkg::LEN_POS)) begin
					len_q <= 1'b1;
				end
			end
			if (dig_acc) begin
				oidx_q <= oidx_q + 3'd1;
			end
		end
	end

	assign digest.word_index = oidx_q;
	assign digest.last_word  = (oidx_q == shs_pkg::LAST_WORD);

	shs_sched u_sched (
		.clk (clk),
		.ctl (sched_ctl),
		.kw  (kw)
	);

	shs_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (rnd_ctl),
		.kw          (kw),
		.digest_word (digest.digest_word)
	);

endmodule

// File: sv/shs_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Sequencing checks on the message and digest channels.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module shs_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_index,
	input logic       out_last
);

	`SHS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken while digest pending")
	`SHS_ASSERT_NOW(a_last_pos, out_valid, out_last == (out_index == shs_pkg::LAST_WORD), "last_word misplaced")
	`SHS_ASSERT_NEXT(a_finish_busy, in_valid && in_ready && (in_func == shs_pkg::FN_FINISH), !in_ready, "ready after finish beat")
	`SHS_ASSERT_NEXT(a_word_order, out_valid && out_ready && !out_last, out_valid && (out_index == $past(out_index) + 3'd1), "digest words out of order")
	`SHS_ASSERT_NEXT(a_idle_after, out_valid && out_ready && out_last, in_ready, "not idle after last digest word")

endmodule

bind sha256_stream_hasher shs_check u_shs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_func   (msg.func),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.out_index (digest.word_index),
	.out_last  (digest.last_word)
);
